// ===== hdl/ehmd_pkg.sv =====
package ehmd_pkg;

  // Command codes of an input beat
  localparam logic CMD_CONTROL = 1'b0;
  localparam logic CMD_DRIVE   = 1'b1;

  // Duty limits and slew steps
  localparam logic [7:0] DUTY_CLAMP      = 8'd210;
  localparam logic [7:0] CLOSE_SLEW_STEP = 8'd5;
  localparam logic [7:0] OPEN_SLEW_STEP  = 8'd2;

  // Scheduled duty levels
  localparam logic [7:0] DUTY_TOP  = 8'd180;
  localparam logic [7:0] DUTY_HIGH = 8'd150;
  localparam logic [7:0] DUTY_MED  = 8'd120;
  localparam logic [7:0] DUTY_LOW  = 8'd100;

  // Band boundaries in units of tick_multiplier. The top bands above 32
  // all give the top level, and the bands above 28 and 20 both give the
  // high level, so they merge into single boundaries.
  localparam logic [9:0] BAND_TOP  = 10'd32;
  localparam logic [9:0] BAND_HIGH = 10'd20;
  localparam logic [9:0] BAND_DIP  = 10'd14;
  localparam logic [9:0] BAND_RISE = 10'd8;
  localparam logic [9:0] BAND_LOW  = 10'd4;
  localparam logic [9:0] BAND_MED  = 10'd2;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [7:0]  RST_PRIMARY    = 8'd50;
  localparam logic [7:0]  RST_AUX        = 8'd30;
  localparam logic [7:0]  RST_DIFFERENCE = 8'd40;
  localparam logic [3:0]  RST_TICK_MULT  = 4'd4;
  localparam logic [7:0]  RST_START_DUTY = 8'd70;
  localparam logic [3:0]  RST_CLOSE_STEP = 4'd2;
  localparam logic [3:0]  RST_OPEN_STEP  = 4'd3;
  localparam logic [15:0] RST_SLEEP_LIM  = 16'd1900;

  typedef enum logic [2:0] {
    CFG_PRIMARY    = 3'd0,
    CFG_AUX        = 3'd1,
    CFG_DIFFERENCE = 3'd2,
    CFG_TICK_MULT  = 3'd3,
    CFG_START_DUTY = 3'd4,
    CFG_CLOSE_STEP = 3'd5,
    CFG_OPEN_STEP  = 3'd6,
    CFG_SLEEP_LIM  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MOT_STOP  = 2'd0,
    MOT_CLOSE = 2'd1,
    MOT_OPEN  = 2'd2
  } motion_e;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_STOP  = 3'd1,
    OP_CLOSE = 3'd2,
    OP_OPEN  = 3'd3,
    OP_DRIVE = 3'd4
  } op_e;

  typedef struct packed {
    logic [7:0]  primary_threshold;
    logic [7:0]  aux_threshold;
    logic [7:0]  difference_threshold;
    logic [3:0]  tick_multiplier;
    logic [7:0]  start_duty;
    logic [3:0]  close_ramp_step;
    logic [3:0]  open_ramp_step;
    logic [15:0] sleep_limit;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] emg_close;
    logic [7:0] emg_open;
  } in_t;

  typedef struct packed {
    logic [1:0] motion_state;
    logic [7:0] target_duty;
    logic [7:0] close_gate_duty;
    logic [7:0] open_gate_duty;
    logic       sleep_request;
  } out_t;

  typedef struct packed {
    logic valid;
    op_e  op;
  } op_chan_t;

endpackage

// ===== hdl/ehmd_front.sv =====
module ehmd_front import ehmd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_t      in_item_i,
  input  cfg_t     cfg_i,
  input  logic     op_take_i,
  output op_chan_t op_o
);

  logic [7:0] emg_c, emg_o, diff;
  op_e        op_cls;
  logic       push_fire, pop_fire;

  op_e        fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // Classify the incoming beat
  always_comb begin
    emg_c = in_item_i.emg_close;
    emg_o = in_item_i.emg_open;
    diff  = (emg_c > emg_o) ? (emg_c - emg_o) : (emg_o - emg_c);
    if (in_item_i.command == CMD_DRIVE) begin
      op_cls = OP_DRIVE;
    end else if (diff > cfg_i.difference_threshold) begin
      op_cls = (emg_c < emg_o) ? OP_OPEN : OP_CLOSE;
    end else if (emg_c < cfg_i.aux_threshold && emg_o < cfg_i.aux_threshold) begin
      op_cls = OP_STOP;
    end else if (emg_c > cfg_i.primary_threshold && emg_o < cfg_i.aux_threshold) begin
      op_cls = OP_CLOSE;
    end else if (emg_c < cfg_i.aux_threshold && emg_o > cfg_i.primary_threshold) begin
      op_cls = OP_OPEN;
    end else if (emg_c > cfg_i.primary_threshold && emg_o > cfg_i.primary_threshold) begin
      op_cls = OP_CLOSE;
    end else begin
      op_cls = OP_HOLD;
    end
  end

  // Two-entry operation queue toward the back end
  assign full      = (cnt_q == 2'd2);
  assign push_fire = push && !full;
  assign pop_fire  = op_take_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push_fire ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_fire ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_fire && pop_fire) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      fifo_q[wr_ptr_q] <= op_cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign op_o.valid = (cnt_q != 2'd0);
  assign op_o.op    = fifo_q[rd_ptr_q];

endmodule

// ===== hdl/ehmd_back.sv =====
module ehmd_back import ehmd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  op_chan_t op_i,
  output logic     op_take_o,
  output logic     empty,
  input  logic     pop,
  output out_t     out_item_o
);

  // Drive state
  motion_e     motion_q, motion_d;
  logic [15:0] hold_q, hold_d;
  logic [7:0]  target_q, target_d;
  logic [7:0]  close_slew_q, close_slew_d;
  logic [7:0]  open_slew_q, open_slew_d;
  logic [15:0] idle_q, idle_d;

  // Schedule datapath
  motion_e     dir;
  logic [15:0] hold_eff;
  logic [3:0]  ramp_step;
  logic [19:0] ramp_prod;
  logic [20:0] ramp_sum;
  logic [7:0]  ramp_duty;
  logic [7:0]  sched_duty;
  logic [9:0]  mult;
  logic [15:0] idle_inc;
  out_t        res;

  // Result queue
  out_t        resq_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop_fire;

  assign pop_fire  = pop && !empty;
  assign op_take_o = op_i.valid && ((cnt_q != 2'd2) || pop_fire);

  // Pick the scheduled duty for a move
  always_comb begin
    dir       = (op_i.op == OP_CLOSE) ? MOT_CLOSE : MOT_OPEN;
    hold_eff  = (motion_q != dir) ? 16'd0 : hold_q;
    ramp_step = (dir == MOT_CLOSE) ? cfg_i.close_ramp_step : cfg_i.open_ramp_step;
    ramp_prod = 20'(hold_eff) * 20'(ramp_step);
    ramp_sum  = 21'(cfg_i.start_duty) + 21'(ramp_prod);
    ramp_duty = (ramp_sum > 21'(DUTY_CLAMP)) ? DUTY_CLAMP : ramp_sum[7:0];
    mult      = 10'(cfg_i.tick_multiplier);
    if (hold_eff > 16'(mult * BAND_TOP)) begin
      sched_duty = DUTY_TOP;
    end else if (hold_eff > 16'(mult * BAND_HIGH)) begin
      sched_duty = DUTY_HIGH;
    end else if (hold_eff > 16'(mult * BAND_DIP)) begin
      sched_duty = DUTY_LOW;
    end else if (hold_eff > 16'(mult * BAND_RISE)) begin
      sched_duty = DUTY_HIGH;
    end else if (hold_eff > 16'(mult * BAND_LOW)) begin
      sched_duty = DUTY_LOW;
    end else if (hold_eff > 16'(mult * BAND_MED)) begin
      sched_duty = DUTY_MED;
    end else if (target_q > DUTY_MED) begin
      sched_duty = DUTY_MED;
    end else begin
      sched_duty = ramp_duty;
    end
  end

  // Apply one operation to the drive state and form its result
  always_comb begin
    motion_d     = motion_q;
    hold_d       = hold_q;
    target_d     = target_q;
    close_slew_d = close_slew_q;
    open_slew_d  = open_slew_q;
    idle_d       = idle_q;
    idle_inc     = idle_q + 16'd1;
    res          = '0;
    unique case (op_i.op)
      OP_STOP: begin
        motion_d     = MOT_STOP;
        close_slew_d = cfg_i.start_duty;
        open_slew_d  = cfg_i.start_duty;
        target_d     = 8'd0;
        hold_d       = 16'd0;
        if (idle_inc > cfg_i.sleep_limit) begin
          idle_d            = 16'd0;
          res.sleep_request = 1'b1;
        end else begin
          idle_d = idle_inc;
        end
      end
      OP_CLOSE, OP_OPEN: begin
        motion_d = dir;
        idle_d   = 16'd0;
        hold_d   = (hold_eff == HOLD_MAX) ? hold_eff : hold_eff + 16'd1;
        target_d = sched_duty;
      end
      OP_DRIVE: begin
        case (motion_q)
          MOT_OPEN: begin
            open_slew_d = (open_slew_q < target_q) ? open_slew_q + OPEN_SLEW_STEP : target_q;
            res.open_gate_duty = open_slew_d;
          end
          MOT_CLOSE: begin
            close_slew_d = (close_slew_q < target_q) ? close_slew_q + CLOSE_SLEW_STEP
                                                     : target_q;
            res.close_gate_duty = close_slew_d;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    res.motion_state = motion_d;
    res.target_duty  = target_d;
  end

  // Commit state on each taken operation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q     <= MOT_STOP;
      hold_q       <= 16'd0;
      target_q     <= RST_START_DUTY;
      close_slew_q <= RST_START_DUTY;
      open_slew_q  <= RST_START_DUTY;
      idle_q       <= 16'd0;
    end else if (op_take_o) begin
      motion_q     <= motion_d;
      hold_q       <= hold_d;
      target_q     <= target_d;
      close_slew_q <= close_slew_d;
      open_slew_q  <= open_slew_d;
      idle_q       <= idle_d;
    end
  end

  // Two-entry result queue
  always_comb begin
    cnt_d = cnt_q;
    if (op_take_o && !pop_fire) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!op_take_o && pop_fire) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_take_o) begin
      resq_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (op_take_o) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_fire) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  assign empty      = (cnt_q == 2'd0);
  assign out_item_o = resq_q[rd_ptr_q];

endmodule

// ===== hdl/emg_hand_motor_drive.sv =====
// Two-channel EMG hand motor drive.
// Input channel: a beat is taken when push is high and full is low. A
// control beat carries the two EMG samples; a drive beat advances the gate
// slew. Every beat gives exactly one result beat.
// Result channel: the oldest result sits on out_item_o while empty is low
// and leaves when pop is high.
// Path: a beat is classified and written into the operation queue, then
// taken, once the result queue has room, and run through the drive state
// into the result queue.
// Throughput: one beat per cycle while pop drains results, set by the
// combinational back-end update (one 16x4 ramp multiply, band compares, clamp).
// Both sides have two-entry queues: when pop stays low the result queue
// fills, then the operation queue, and full rises after four beats held.
// Reset: all queues empty, motion stopped, target and slews at the reset
// start duty, registers at reset values. The user writes registers with
// cfg_we_i, cfg_idx_i, cfg_wdata_i only while idle; the block does not check.
module emg_hand_motor_drive import ehmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_t         in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_t        out_item_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t     cfg_q;
  op_chan_t op_chan;
  logic     op_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.primary_threshold    <= RST_PRIMARY;
      cfg_q.aux_threshold        <= RST_AUX;
      cfg_q.difference_threshold <= RST_DIFFERENCE;
      cfg_q.tick_multiplier      <= RST_TICK_MULT;
      cfg_q.start_duty           <= RST_START_DUTY;
      cfg_q.close_ramp_step      <= RST_CLOSE_STEP;
      cfg_q.open_ramp_step       <= RST_OPEN_STEP;
      cfg_q.sleep_limit          <= RST_SLEEP_LIM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PRIMARY:    cfg_q.primary_threshold    <= cfg_wdata_i[7:0];
        CFG_AUX:        cfg_q.aux_threshold        <= cfg_wdata_i[7:0];
        CFG_DIFFERENCE: cfg_q.difference_threshold <= cfg_wdata_i[7:0];
        CFG_TICK_MULT:  cfg_q.tick_multiplier      <= cfg_wdata_i[3:0];
        CFG_START_DUTY: cfg_q.start_duty           <= cfg_wdata_i[7:0];
        CFG_CLOSE_STEP: cfg_q.close_ramp_step      <= cfg_wdata_i[3:0];
        CFG_OPEN_STEP:  cfg_q.open_ramp_step       <= cfg_wdata_i[3:0];
        CFG_SLEEP_LIM:  cfg_q.sleep_limit          <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ehmd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .op_take_i (op_take),
    .op_o      (op_chan)
  );

  ehmd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_i       (op_chan),
    .op_take_o  (op_take),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ===== hdl/ehmd_checker.sv =====
module ehmd_checker import ehmd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input out_t out_item_o
);

  // A close gate only drives while closing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.close_gate_duty != 8'd0) |->
      (out_item_o.motion_state == MOT_CLOSE && out_item_o.open_gate_duty == 8'd0))
    else $error("close gate active outside close motion");

  // An open gate only drives while opening
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.open_gate_duty != 8'd0) |->
      (out_item_o.motion_state == MOT_OPEN && out_item_o.close_gate_duty == 8'd0))
    else $error("open gate active outside open motion");

  // The scheduled target never passes the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.target_duty <= DUTY_CLAMP))
    else $error("target duty above clamp");

  // A sleep request only comes with a stop and zero target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.sleep_request) |->
      (out_item_o.motion_state == MOT_STOP && out_item_o.target_duty == 8'd0))
    else $error("sleep request without stop");

  // A waiting result beat holds until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result beat changed while stalled");

endmodule

bind emg_hand_motor_drive ehmd_checker u_ehmd_checker (.*);
